[rtl/tclc_pkg.sv]
// Shared types, character constants and helpers for the text command LED controller.
package tclc_pkg;

  // Default sizes handed to the top level
  localparam int unsigned LINE_CAPACITY_DEF  = 32;
  localparam int unsigned FIELD_CAPACITY_DEF = 16;

  // Result codes reported with every item
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BUFFERED = 3'd1,
    EV_LED1     = 3'd2,
    EV_LED2     = 3'd3,
    EV_BLINK    = 3'd4,
    EV_STATUS   = 3'd5,
    EV_IGNORED  = 3'd6,
    EV_TOGGLE   = 3'd7
  } event_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_RUN
  } state_e;

  // Input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_ONE  = 8'h31;

  // Command words, right-aligned, first character in the highest byte
  localparam logic [47:0] TXT_STATUS = 48'h535441545553; // STATUS
  localparam logic [47:0] TXT_LED1   = 48'h00004C454431; // LED1
  localparam logic [47:0] TXT_LED2   = 48'h00004C454432; // LED2
  localparam logic [47:0] TXT_BLINK  = 48'h00424C494E4B; // BLINK
  localparam logic [47:0] TXT_ON     = 48'h000000004F4E; // ON

  localparam logic [2:0] LEN_STATUS = 3'd6;
  localparam logic [2:0] LEN_LED    = 3'd4;
  localparam logic [2:0] LEN_BLINK  = 3'd5;
  localparam logic [2:0] LEN_ON     = 3'd2;

  // Duty limit and reciprocal of 100 scaled by 255 * 2^16
  localparam logic [6:0]  DUTY_MAX   = 7'd100;
  localparam logic [17:0] PWM_RECIP  = 18'd167117;
  localparam int unsigned PWM_SHIFT  = 16;

  // Character i of a word of length n
  function automatic logic [7:0] txt_at(logic [47:0] txt, logic [2:0] n, logic [2:0] i);
    logic [5:0] sh;
    sh = {3'(n - 3'd1 - i), 3'b000};
    return txt[sh +: 8];
  endfunction

endpackage

[rtl/tclc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tclc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; reading the address being written returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/text_command_led_controller.sv]
// Top level of the text command LED controller: line buffer, line scanner and LED state.
//
// A byte item or a millisecond tick item is taken and its result is loaded
// into the output register in that same cycle. A CR or LF item runs the
// buffered line: the scanner reads the line RAM one character a cycle
// through its registered read port. The line end passes through the prime,
// scan and run states, and an empty line goes straight to the run state,
// which loads the result once the output register is free. The block takes
// no item while a line is scanned or while the output register holds a
// result that is not yet taken and cannot be replaced. tuser carries the
// kind of an input item (0 byte, 1 tick) and the event code of a result item.
module text_command_led_controller
  import tclc_pkg::*;
#(
  parameter int unsigned LINE_CAPACITY  = LINE_CAPACITY_DEF,
  parameter int unsigned FIELD_CAPACITY = FIELD_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [6:0] duty_percent, [14:7] pwm_level,
                                        // [15] led2_on, [31:16] blink_interval
  output logic [2:0]  m_axis_tuser_o    // [2:0] event_res
);

  localparam int unsigned DEPTH = LINE_CAPACITY - 1;
  localparam int unsigned LW    = $clog2(LINE_CAPACITY);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned VW    = $clog2(FIELD_CAPACITY);
  localparam logic [LW-1:0] LINE_MAX  = LW'(LINE_CAPACITY - 1);
  localparam logic [VW-1:0] VALUE_MAX = VW'(FIELD_CAPACITY - 1);

  state_e        state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] pos_q, pos_d;
  logic          eq_seen_q, eq_seen_d;
  logic [LW-1:0] eq_pos_q, eq_pos_d;
  logic          st_ok_q, st_ok_d;
  logic          l1_ok_q, l1_ok_d;
  logic          l2_ok_q, l2_ok_d;
  logic          bk_ok_q, bk_ok_d;
  logic          dig_q, dig_d;
  logic [15:0]   num_q, num_d;
  logic [VW-1:0] vcnt_q, vcnt_d;
  logic          v0_one_q, v0_one_d;
  logic          on_ok_q, on_ok_d;
  logic [6:0]    duty_q, duty_d;
  logic          led2_q, led2_d;
  logic [15:0]   period_q, period_d;
  logic [15:0]   elapsed_q, elapsed_d;

  logic          m_valid_q, m_valid_d;
  event_e        out_ev_q, out_ev_d;
  logic [6:0]    out_duty_q;
  logic [7:0]    out_pwm_q, pwm_d;
  logic          out_led2_q;
  logic [15:0]   out_period_q;
  logic          out_load;

  logic          s_accept;
  logic          out_free;
  logic          is_term;
  logic          scan_last;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [7:0]    ch;
  logic [2:0]    pidx;
  logic [15:0]   elapsed_inc;
  logic [24:0]   pwm_prod;
  logic [7:0]    num_low;

  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign s_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign is_term   = (s_axis_tdata_i == CH_CR) || (s_axis_tdata_i == CH_LF);
  assign scan_last = (pos_q == len_q - LW'(1));
  assign ch        = ram_rdata;
  assign pidx      = pos_q[2:0];

  // Line RAM
  tclc_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept && s_axis_tuser_i == FUNC_BYTE && is_term) begin
          state_d = (len_q == '0) ? S_RUN : S_PRIME;
        end
      end
      S_PRIME: state_d = S_SCAN;
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and RAM control
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE) && out_free;
    ram_we          = s_accept && s_axis_tuser_i == FUNC_BYTE && !is_term
                      && (len_q < LINE_MAX);
    ram_waddr       = AW'(len_q);
    ram_raddr       = (state_q == S_SCAN) ? AW'(pos_q + LW'(1)) : AW'(pos_q);
  end

  // Datapath: buffering, ticks, scan step and command execution
  always_comb begin
    len_d     = len_q;
    pos_d     = pos_q;
    eq_seen_d = eq_seen_q;
    eq_pos_d  = eq_pos_q;
    st_ok_d   = st_ok_q;
    l1_ok_d   = l1_ok_q;
    l2_ok_d   = l2_ok_q;
    bk_ok_d   = bk_ok_q;
    dig_d     = dig_q;
    num_d     = num_q;
    vcnt_d    = vcnt_q;
    v0_one_d  = v0_one_q;
    on_ok_d   = on_ok_q;
    duty_d    = duty_q;
    led2_d    = led2_q;
    period_d  = period_q;
    elapsed_d = elapsed_q;
    out_ev_d  = EV_NONE;
    out_load  = 1'b0;
    elapsed_inc = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
    num_low   = num_q[7:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser_i == FUNC_BYTE) begin
            if (is_term) begin
              // Clear the scan flags and start on the line
              pos_d     = '0;
              eq_seen_d = 1'b0;
              eq_pos_d  = '0;
              st_ok_d   = 1'b1;
              l1_ok_d   = 1'b1;
              l2_ok_d   = 1'b1;
              bk_ok_d   = 1'b1;
              dig_d     = 1'b1;
              num_d     = '0;
              vcnt_d    = '0;
              v0_one_d  = 1'b0;
              on_ok_d   = 1'b1;
            end else if (len_q < LINE_MAX) begin
              len_d    = len_q + LW'(1);
              out_ev_d = EV_BUFFERED;
              out_load = 1'b1;
            end else begin
              // Drop the byte: the line is full
              out_ev_d = EV_NONE;
              out_load = 1'b1;
            end
          end else begin
            out_load = 1'b1;
            if (period_q != '0) begin
              if (elapsed_inc >= period_q) begin
                led2_d    = !led2_q;
                elapsed_d = '0;
                out_ev_d  = EV_TOGGLE;
              end else begin
                elapsed_d = elapsed_inc;
              end
            end
          end
        end
      end

      S_PRIME: ;

      S_SCAN: begin
        pos_d = pos_q + LW'(1);
        if (!eq_seen_q) begin
          if (ch == CH_EQ) begin
            eq_seen_d = 1'b1;
            eq_pos_d  = pos_q;
          end else begin
            // Key characters: drop each word that no longer matches
            if (pos_q >= LW'(LEN_STATUS) || ch != txt_at(TXT_STATUS, LEN_STATUS, pidx)) begin
              st_ok_d = 1'b0;
            end
            if (pos_q >= LW'(LEN_LED) || ch != txt_at(TXT_LED1, LEN_LED, pidx)) begin
              l1_ok_d = 1'b0;
            end
            if (pos_q >= LW'(LEN_LED) || ch != txt_at(TXT_LED2, LEN_LED, pidx)) begin
              l2_ok_d = 1'b0;
            end
            if (pos_q >= LW'(LEN_BLINK) || ch != txt_at(TXT_BLINK, LEN_BLINK, pidx)) begin
              bk_ok_d = 1'b0;
            end
          end
        end else if (vcnt_q < VALUE_MAX) begin
          // Value characters up to the field limit
          vcnt_d = vcnt_q + VW'(1);
          if (vcnt_q == '0) begin
            v0_one_d = (ch == CH_ONE);
          end
          if (vcnt_q < VW'(LEN_ON)
              && ch != txt_at(TXT_ON, LEN_ON, {2'b00, vcnt_q[0]})) begin
            on_ok_d = 1'b0;
          end
          if (dig_q && ch >= CH_ZERO && ch <= CH_NINE) begin
            num_d = {num_q[12:0], 3'b000} + {num_q[14:0], 1'b0}
                    + {12'd0, 4'(ch - CH_ZERO)};
          end else begin
            dig_d = 1'b0;
          end
        end
      end

      S_RUN: begin
        if (out_free) begin
          out_load = 1'b1;
          len_d    = '0;
          if (!eq_seen_q) begin
            out_ev_d = (st_ok_q && len_q == LW'(LEN_STATUS)) ? EV_STATUS : EV_IGNORED;
          end else if (l1_ok_q && eq_pos_q == LW'(LEN_LED)) begin
            duty_d   = (num_low > 8'(DUTY_MAX)) ? DUTY_MAX : num_low[6:0];
            out_ev_d = EV_LED1;
          end else if (l2_ok_q && eq_pos_q == LW'(LEN_LED)) begin
            led2_d   = v0_one_q || (on_ok_q && vcnt_q == VW'(LEN_ON));
            out_ev_d = EV_LED2;
          end else if (bk_ok_q && eq_pos_q == LW'(LEN_BLINK)) begin
            period_d  = num_q;
            elapsed_d = '0;
            out_ev_d  = EV_BLINK;
          end else begin
            out_ev_d = EV_IGNORED;
          end
        end
      end

      default: ;
    endcase

    // Hold a result until the sink takes it
    m_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);
  end

  // PWM level from the new duty
  assign pwm_prod = 25'(duty_d) * 25'(PWM_RECIP);
  assign pwm_d    = pwm_prod[PWM_SHIFT +: 8];

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      len_q     <= '0;
      duty_q    <= '0;
      led2_q    <= 1'b0;
      period_q  <= '0;
      elapsed_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      duty_q    <= duty_d;
      led2_q    <= led2_d;
      period_q  <= period_d;
      elapsed_q <= elapsed_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Scan and output payload registers
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    eq_seen_q <= eq_seen_d;
    eq_pos_q  <= eq_pos_d;
    st_ok_q   <= st_ok_d;
    l1_ok_q   <= l1_ok_d;
    l2_ok_q   <= l2_ok_d;
    bk_ok_q   <= bk_ok_d;
    dig_q     <= dig_d;
    num_q     <= num_d;
    vcnt_q    <= vcnt_d;
    v0_one_q  <= v0_one_d;
    on_ok_q   <= on_ok_d;
    if (out_load) begin
      out_ev_q     <= out_ev_d;
      out_duty_q   <= duty_d;
      out_pwm_q    <= pwm_d;
      out_led2_q   <= led2_d;
      out_period_q <= period_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_ev_q;
  assign m_axis_tdata_o  = {out_period_q, out_led2_q, out_pwm_q, out_duty_q};

  // The line never grows past its capacity
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LINE_MAX)
    else $error("line length beyond capacity");

  // The duty stays within 0 to 100
  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q <= DUTY_MAX)
    else $error("duty above 100");

  // The blink count stays below a running period
  a_elapsed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (elapsed_q < period_q) || (elapsed_q == '0))
    else $error("blink count reached its period");

  // A non-empty line end holds off the next item while the line is scanned
  a_scan_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser_i == FUNC_BYTE && is_term && len_q != '0)
      |=> !s_axis_tready_o)
    else $error("item taken during a line scan");

endmodule
